// ===== sv/device_slot_table_oldest_offline_evict_top_macros.svh =====
// Assertion macros used by the device slot table top module.
`ifndef DEVICE_SLOT_TABLE_OLDEST_OFFLINE_EVICT_TOP_MACROS_SVH
`define DEVICE_SLOT_TABLE_OLDEST_OFFLINE_EVICT_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define DSTO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DSTO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dsto_pkg.sv =====
// Types and codes for the device slot table.
package dsto_pkg;

    localparam int SERIAL_W = 64;
    localparam int TIME_W   = 32;
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 5;
    localparam int CODE_W   = 3;
    localparam int IN_W     = 104;
    localparam int OUT_W    = 8;

    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_OFFLINE = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
    localparam logic [OP_W-1:0] OP_ONLINE  = 3'd4;

    localparam logic [CODE_W-1:0] RES_REFRESHED = 3'd0;
    localparam logic [CODE_W-1:0] RES_INSERTED  = 3'd1;
    localparam logic [CODE_W-1:0] RES_REPLACED  = 3'd2;
    localparam logic [CODE_W-1:0] RES_DROPPED   = 3'd3;
    localparam logic [CODE_W-1:0] RES_DONE      = 3'd4;
    localparam logic [CODE_W-1:0] RES_NOT_FOUND = 3'd5;

    // Write controls from the sequencer to the slot store.
    typedef struct packed {
        logic we;
        logic set_valid;
        logic clr_valid;
        logic online_we;
        logic online_val;
    } t_slot_wr;

    // Candidates found by the scan.
    typedef struct packed {
        logic match;
        logic empty;
        logic oldest;
    } t_scan_flags;

endpackage

// ===== sv/dsto_slot_store.sv =====
// Slot storage: serial and time memories, valid and online flags.
module dsto_slot_store #(
    parameter int NUM_SLOTS = 16,
    parameter int IW        = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [IW-1:0]                  i_rd_addr,
    output logic                           o_rd_valid,
    output logic [dsto_pkg::SERIAL_W-1:0]  o_rd_serial,
    output logic [dsto_pkg::TIME_W-1:0]    o_rd_time,
    output logic                           o_rd_online,
    input  dsto_pkg::t_slot_wr             i_wr,
    input  logic [IW-1:0]                  i_wr_addr,
    input  logic [dsto_pkg::SERIAL_W-1:0]  i_wr_serial,
    input  logic [dsto_pkg::TIME_W-1:0]    i_wr_time
);

    logic [dsto_pkg::SERIAL_W-1:0] mem_serial [NUM_SLOTS];
    logic [dsto_pkg::TIME_W-1:0]   mem_time   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          r_valid;
    logic [NUM_SLOTS-1:0]          r_online;
    logic                          r_rd_valid;
    logic [dsto_pkg::SERIAL_W-1:0] r_rd_serial;
    logic [dsto_pkg::TIME_W-1:0]   r_rd_time;
    logic                          r_rd_online;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem_serial[i_wr_addr] <= i_wr_serial;
            mem_time[i_wr_addr]   <= i_wr_time;
        end
        r_rd_serial <= mem_serial[i_rd_addr];
        r_rd_time   <= mem_time[i_rd_addr];
        r_rd_valid  <= r_valid[i_rd_addr];
        r_rd_online <= r_online[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_online <= '0;
        end else begin
            if (i_wr.set_valid) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_wr.clr_valid) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_wr.online_we) begin
                r_online[i_wr_addr] <= i_wr.online_val;
            end
        end
    end

    // An entry that is not valid reads as empty: serial and time zero.
    assign o_rd_valid  = r_rd_valid;
    assign o_rd_serial = r_rd_valid ? r_rd_serial : '0;
    assign o_rd_time   = r_rd_valid ? r_rd_time : '0;
    assign o_rd_online = r_rd_online;

endmodule

// ===== sv/dsto_scan_unit.sv =====
// Shared compare unit: key match, empty slot and oldest offline slot tracking.
module dsto_scan_unit #(
    parameter int IW = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_cmp_valid,
    input  logic [IW-1:0]                  i_cmp_idx,
    input  logic [dsto_pkg::SERIAL_W-1:0]  i_key,
    input  logic                           i_rd_valid,
    input  logic [dsto_pkg::SERIAL_W-1:0]  i_rd_serial,
    input  logic [dsto_pkg::TIME_W-1:0]    i_rd_time,
    input  logic                           i_rd_online,
    output logic                           o_hit,
    output dsto_pkg::t_scan_flags          o_flags,
    output logic [IW-1:0]                  o_match_idx,
    output logic [IW-1:0]                  o_empty_idx,
    output logic [IW-1:0]                  o_old_idx
);

    dsto_pkg::t_scan_flags       r_flags;
    logic [IW-1:0]               r_match_idx;
    logic [IW-1:0]               r_empty_idx;
    logic [IW-1:0]               r_old_idx;
    logic [dsto_pkg::TIME_W-1:0] r_old_time;
    logic                        older;

    assign o_hit = i_cmp_valid && i_rd_valid && (i_rd_serial == i_key);
    // Strictly older only, so the lowest index keeps a tie.
    assign older = !i_rd_online && (!r_flags.oldest || (i_rd_time < r_old_time));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_cmp_valid) begin
            if (o_hit) begin
                r_flags.match <= 1'b1;
            end
            if (!i_rd_valid && !r_flags.empty) begin
                r_flags.empty <= 1'b1;
            end
            if (older) begin
                r_flags.oldest <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_valid) begin
            if (o_hit) begin
                r_match_idx <= i_cmp_idx;
            end
            if (!i_rd_valid && !r_flags.empty) begin
                r_empty_idx <= i_cmp_idx;
            end
            if (older) begin
                r_old_idx  <= i_cmp_idx;
                r_old_time <= i_rd_time;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_match_idx = r_match_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_old_idx   = r_old_idx;

endmodule

// ===== sv/device_slot_table_oldest_offline_evict_top.sv =====
// Device slot table with oldest-offline eviction: sequencer and stream ports.
//
//  channel | dir | tdata fields (low bit up)                      | handshake
//  s_axis  | in  | opcode[2:0] device_serial[66:3] seen_time[98:67] | tvalid/tready
//  m_axis  | out | slot_address[4:0] outcome[7:5]                | tvalid/tready
//
// An operation reads the slot memory once per cycle through the shared compare
// unit, from slot 0 up to the last slot; a hit ends the scan early, and a zero
// serial or unknown opcode skips the scan. Input is not ready during the scan.
// Reset clears every slot at once through the valid and online flags.
// A result waits in the output register; the next item is accepted meanwhile,
// and its scan holds at the end until the output register is free.
`include "device_slot_table_oldest_offline_evict_top_macros.svh"

module device_slot_table_oldest_offline_evict_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // opcode[2:0], device_serial[66:3], seen_time[98:67], zero[103:99]
    input  logic [dsto_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // slot_address[4:0], outcome[7:5]
    output logic [dsto_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                        r_state;
    logic [dsto_pkg::OP_W-1:0]     r_op;
    logic [dsto_pkg::SERIAL_W-1:0] r_key;
    logic [dsto_pkg::TIME_W-1:0]   r_time;
    logic                          r_skip;
    logic [IW-1:0]                 r_idx;
    logic                          r_issue;
    logic                          r_cv;
    logic [IW-1:0]                 r_ci;
    logic                          r_out_valid;
    logic [dsto_pkg::ADDR_W-1:0]   r_out_addr;
    logic [dsto_pkg::CODE_W-1:0]   r_out_code;

    logic                          in_fire;
    logic [dsto_pkg::OP_W-1:0]     in_op;
    logic [dsto_pkg::SERIAL_W-1:0] in_serial;
    logic [dsto_pkg::TIME_W-1:0]   in_time;
    logic                          out_free;
    logic                          done_go;
    logic                          cmp_valid;
    logic                          scan_end;

    logic                          rd_valid;
    logic [dsto_pkg::SERIAL_W-1:0] rd_serial;
    logic [dsto_pkg::TIME_W-1:0]   rd_time;
    logic                          rd_online;
    logic                          hit;
    dsto_pkg::t_scan_flags         flags;
    logic [IW-1:0]                 match_idx;
    logic [IW-1:0]                 empty_idx;
    logic [IW-1:0]                 old_idx;

    dsto_pkg::t_slot_wr            wr;
    dsto_pkg::t_slot_wr            wr_go;
    logic [IW-1:0]                 wr_addr;
    logic                          res_has;
    logic [dsto_pkg::CODE_W-1:0]   res_code;
    logic [6:0]                    res_sum;

    assign in_op     = i_s_axis_tdata[2:0];
    assign in_serial = i_s_axis_tdata[66:3];
    assign in_time   = i_s_axis_tdata[98:67];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign done_go         = (r_state == S_DONE) && out_free;
    assign cmp_valid       = r_cv && (r_state == S_SCAN);
    assign scan_end        = cmp_valid && (hit || (r_ci == LAST));

    dsto_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (r_idx),
        .o_rd_valid  (rd_valid),
        .o_rd_serial (rd_serial),
        .o_rd_time   (rd_time),
        .o_rd_online (rd_online),
        .i_wr        (wr_go),
        .i_wr_addr   (wr_addr),
        .i_wr_serial (r_key),
        .i_wr_time   (r_time)
    );

    dsto_scan_unit #(
        .IW (IW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_fire),
        .i_cmp_valid (cmp_valid),
        .i_cmp_idx   (r_ci),
        .i_key       (r_key),
        .i_rd_valid  (rd_valid),
        .i_rd_serial (rd_serial),
        .i_rd_time   (rd_time),
        .i_rd_online (rd_online),
        .o_hit       (hit),
        .o_flags     (flags),
        .o_match_idx (match_idx),
        .o_empty_idx (empty_idx),
        .o_old_idx   (old_idx)
    );

    // Decide the write and the result once the scan is over.
    always_comb begin
        wr       = '0;
        wr_addr  = match_idx;
        res_has  = 1'b0;
        res_code = dsto_pkg::RES_NOT_FOUND;
        if (r_skip) begin
            res_code = (r_op == dsto_pkg::OP_UPDATE) ? dsto_pkg::RES_DROPPED
                                                     : dsto_pkg::RES_NOT_FOUND;
        end else if (r_op == dsto_pkg::OP_UPDATE) begin
            if (flags.match) begin
                wr.we    = 1'b1;
                res_has  = 1'b1;
                res_code = dsto_pkg::RES_REFRESHED;
            end else if (flags.empty) begin
                wr.we        = 1'b1;
                wr.set_valid = 1'b1;
                wr_addr      = empty_idx;
                res_has      = 1'b1;
                res_code     = dsto_pkg::RES_INSERTED;
            end else if (flags.oldest) begin
                wr.we    = 1'b1;
                wr_addr  = old_idx;
                res_has  = 1'b1;
                res_code = dsto_pkg::RES_REPLACED;
            end else begin
                res_code = dsto_pkg::RES_DROPPED;
            end
        end else if (flags.match) begin
            res_has  = 1'b1;
            res_code = dsto_pkg::RES_DONE;
            unique case (r_op)
                dsto_pkg::OP_OFFLINE: begin
                    wr.online_we  = 1'b1;
                    wr.online_val = 1'b0;
                end
                dsto_pkg::OP_ONLINE: begin
                    wr.online_we  = 1'b1;
                    wr.online_val = 1'b1;
                end
                dsto_pkg::OP_DELETE: begin
                    wr.clr_valid  = 1'b1;
                    wr.online_we  = 1'b1;
                    wr.online_val = 1'b0;
                end
                default: begin
                    wr = '0;
                end
            endcase
        end
    end

    assign wr_go   = done_go ? wr : '0;
    assign res_sum = 7'(wr_addr) + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cv <= 1'b0;
                        if ((in_serial == '0) || (in_op > dsto_pkg::OP_ONLINE)) begin
                            r_state <= S_DONE;
                            r_issue <= 1'b0;
                        end else begin
                            r_state <= S_SCAN;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        r_state <= S_DONE;
                        r_issue <= 1'b0;
                        r_cv    <= 1'b0;
                    end else begin
                        r_cv <= r_issue;
                        if (r_issue && (r_idx == LAST)) begin
                            r_issue <= 1'b0;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item, scan and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= in_op;
            r_key  <= in_serial;
            r_time <= in_time;
            r_skip <= (in_serial == '0) || (in_op > dsto_pkg::OP_ONLINE);
            r_idx  <= '0;
        end else if (r_issue && (r_idx != LAST)) begin
            r_idx <= r_idx + IW'(1);
        end
        r_ci <= r_idx;
        if (done_go) begin
            r_out_addr <= res_has ? res_sum[4:0] : '0;
            r_out_code <= res_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_code, r_out_addr};

    `DSTO_ASSERT_NEXT(a_fire_starts_op, i_clk, i_rst_n, in_fire, (r_state == S_SCAN) || (r_state == S_DONE), "accepted item did not start an operation")
    `DSTO_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, done_go, o_m_axis_tvalid && (r_state == S_IDLE), "finished operation produced no result")
    `DSTO_ASSERT_NOW(a_issue_in_scan, i_clk, i_rst_n, r_issue, r_state == S_SCAN, "slot read issued outside the scan")
    `DSTO_ASSERT_NEXT(a_hit_ends_scan, i_clk, i_rst_n, hit, (r_state == S_DONE) && flags.match, "key match did not end the scan")

endmodule
